// File: src/csa_pkg.sv
package csa_pkg;

	localparam int XW = 64;
	localparam int AW = 3;
	localparam int SW = 2;

	typedef enum logic [AW-1:0] {
		ACT_ADD = 3'd0,
		ACT_SUB = 3'd1,
		ACT_MUL = 3'd2,
		ACT_POW = 3'd3,
		ACT_DIV = 3'd4
	} act_t;

	typedef enum logic [SW-1:0] {
		ST_OK     = 2'd0,
		ST_OVF    = 2'd1,
		ST_DIV0   = 2'd2,
		ST_NEGEXP = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_MUL,
		S_DIV,
		S_PSQ,
		S_PSQW,
		S_PML,
		S_PMLW,
		S_PEND,
		S_FIN
	} state_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} unit_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

// File: src/csa_req_if.sv
interface csa_req_if import csa_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [AW-1:0]        action;
	logic signed [XW-1:0] operand_a;
	logic signed [XW-1:0] operand_b;

	modport source (output valid, action, operand_a, operand_b, input ready);
	modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface

// File: src/csa_rsp_if.sv
interface csa_rsp_if import csa_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic signed [XW-1:0] value;
	logic [SW-1:0]        status;

	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

// File: src/csa_muldiv.sv
module csa_muldiv import csa_pkg::*; #(
	parameter int W = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  unit_cmd_t      cmd,
	input  logic [W-1:0]   x,
	input  logic [W-1:0]   y,
	output unit_sts_t      sts,
	output logic [2*W-1:0] acc
);

	localparam int CW = $clog2(W + 1);

	logic [2*W-1:0] acc_q;
	logic [W-1:0]   y_q;
	logic           is_div_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [2*W-1:0] sh;
	logic [W:0]     lhs;
	logic [W:0]     rhs;
	logic [W:0]     sum;
	logic [2*W-1:0] acc_d;

	always_comb begin
		sh = {acc_q[2*W-2:0], 1'b0};
		if (is_div_q) begin
			lhs = {acc_q[2*W-1], sh[2*W-1:W]};
			rhs = ~{1'b0, y_q};
		end else begin
			lhs = {1'b0, acc_q[2*W-1:W]};
			rhs = {1'b0, y_q};
		end
		sum = lhs + rhs + {{W{1'b0}}, is_div_q};
		if (is_div_q) begin
			if (!sum[W]) begin
				acc_d = {sum[W-1:0], sh[W-1:1], 1'b1};
			end else begin
				acc_d = sh;
			end
		end else begin
			if (acc_q[0]) begin
				acc_d = {sum, acc_q[W-1:1]};
			end else begin
				acc_d = {1'b0, acc_q[2*W-1:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			is_div_q <= cmd.is_div;
			acc_q    <= {{W{1'b0}}, (cmd.is_div ? x : y)};
			y_q      <= cmd.is_div ? y : x;
		end else if (busy_q) begin
			acc_q <= acc_d;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign acc      = acc_q;

endmodule

// File: src/checked_signed_alu.sv
// overflow-checked signed alu: add, subtract, multiply, power, divide
// req channel carries action, operand_a and operand_b; only the low
// DATA_WIDTH bits of each operand count, as a two's complement value
// rsp channel returns value (sign-extended to 64 bits) and status
// add, subtract, unused actions and early-settled cases go from decode straight to finish
// multiply and divide: one bit per cycle through
// the shared shift-add / restoring-divide unit
// power: square-and-multiply over clog2(DATA_WIDTH) exponent bits, each
// square or multiply being one pass of the same unit
// one request at a time; req.ready is high only while the block is idle
// the result sits in an output register, so a new request is taken while
// an earlier result waits for rsp.ready; a stalled receiver holds the
// next finished result inside until the output register frees up
// reset clears the sequencer and the output valid; no result is pending
module checked_signed_alu import csa_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input logic       clk,
	input logic       arst_n,
	csa_req_if.sink   req,
	csa_rsp_if.source rsp
);

	localparam int W  = DATA_WIDTH;
	localparam int EB = $clog2(W);
	localparam int RW = $clog2(EB + 1);
	localparam logic [W-1:0] LIM = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONE = W'(1);

	state_t state_q, state_d;

	act_t          op_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic          neg_q;
	logic [W-1:0]  p_q;
	logic          ovf_q;
	logic [EB-1:0] exp_q;
	logic [RW-1:0] rnd_q;
	logic [W-1:0]  res_q;
	stat_t         st_q;

	logic                 ovld_q;
	logic signed [XW-1:0] oval_q;
	stat_t                ost_q;

	unit_cmd_t      cmd;
	unit_sts_t      usts;
	logic [W-1:0]   ux;
	logic [W-1:0]   uy;
	logic [2*W-1:0] uacc;

	logic [W-1:0] ma;
	logic [W-1:0] mb;
	logic [W-1:0] r_add;
	logic         add_ovf;
	logic         pneg;
	logic         set_res;
	logic [W-1:0] nres;
	stat_t        nst;
	logic         step_ok;

	function automatic logic fits(input logic neg, input logic [2*W-1:0] m);
		logic [W-1:0] lo;
		lo = m[W-1:0];
		return (m[2*W-1:W] == '0) && (neg ? (lo <= LIM) : (lo < LIM));
	endfunction

	function automatic logic [W-1:0] from_sm(input logic neg, input logic [W-1:0] m);
		return neg ? (W'(0) - m) : m;
	endfunction

	csa_muldiv #(.W(W)) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.x      (ux),
		.y      (uy),
		.sts    (usts),
		.acc    (uacc)
	);

	assign ma   = a_q[W-1] ? (W'(0) - a_q) : a_q;
	assign mb   = b_q[W-1] ? (W'(0) - b_q) : b_q;
	assign pneg = a_q[W-1] & b_q[0];
	assign step_ok = fits(neg_q, uacc);

	always_comb begin
		r_add   = (op_q == ACT_SUB) ? (a_q - b_q) : (a_q + b_q);
		if (op_q == ACT_SUB) begin
			add_ovf = (a_q[W-1] != b_q[W-1]) && (r_add[W-1] != a_q[W-1]);
		end else begin
			add_ovf = (a_q[W-1] == b_q[W-1]) && (r_add[W-1] != a_q[W-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.start  = 1'b0;
		cmd.is_div = 1'b0;
		ux         = ma;
		uy         = mb;
		set_res    = 1'b0;
		nres       = '0;
		nst        = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				case (op_q)
					ACT_ADD, ACT_SUB: begin
						set_res = 1'b1;
						nst     = add_ovf ? ST_OVF : ST_OK;
						nres    = add_ovf ? '0 : r_add;
						state_d = S_FIN;
					end
					ACT_MUL: begin
						if (ma == '0 || mb == '0) begin
							set_res = 1'b1;
							state_d = S_FIN;
						end else begin
							cmd.start = 1'b1;
							state_d   = S_MUL;
						end
					end
					ACT_POW: begin
						if (b_q[W-1]) begin
							set_res = 1'b1;
							nst     = ST_NEGEXP;
							state_d = S_FIN;
						end else if (b_q == '0) begin
							set_res = 1'b1;
							nres    = ONE;
							state_d = S_FIN;
						end else if (ma <= ONE) begin
							set_res = 1'b1;
							nres    = from_sm(pneg, ma);
							state_d = S_FIN;
						end else if (b_q >= W'(W)) begin
							set_res = 1'b1;
							nst     = ST_OVF;
							state_d = S_FIN;
						end else begin
							state_d = S_PSQ;
						end
					end
					ACT_DIV: begin
						if (mb == '0) begin
							set_res = 1'b1;
							nst     = ST_DIV0;
							state_d = S_FIN;
						end else begin
							cmd.start  = 1'b1;
							cmd.is_div = 1'b1;
							state_d    = S_DIV;
						end
					end
					default: begin
						set_res = 1'b1;
						state_d = S_FIN;
					end
				endcase
			end
			S_MUL: begin
				if (usts.done) begin
					set_res = 1'b1;
					nst     = step_ok ? ST_OK : ST_OVF;
					nres    = step_ok ? from_sm(neg_q, uacc[W-1:0]) : '0;
					state_d = S_FIN;
				end
			end
			S_DIV: begin
				if (usts.done) begin
					set_res = 1'b1;
					if (fits(neg_q, {{W{1'b0}}, uacc[W-1:0]})) begin
						nres = from_sm(neg_q, uacc[W-1:0]);
					end else begin
						nst = ST_OVF;
					end
					state_d = S_FIN;
				end
			end
			S_PSQ: begin
				cmd.start = 1'b1;
				ux        = p_q;
				uy        = p_q;
				state_d   = S_PSQW;
			end
			S_PSQW: begin
				if (usts.done) begin
					if (exp_q[EB-1]) begin
						state_d = S_PML;
					end else if (rnd_q == RW'(1)) begin
						state_d = S_PEND;
					end else begin
						state_d = S_PSQ;
					end
				end
			end
			S_PML: begin
				cmd.start = 1'b1;
				ux        = p_q;
				uy        = ma;
				state_d   = S_PMLW;
			end
			S_PMLW: begin
				if (usts.done) begin
					state_d = (rnd_q == RW'(1)) ? S_PEND : S_PSQ;
				end
			end
			S_PEND: begin
				set_res = 1'b1;
				nst     = ovf_q ? ST_OVF : ST_OK;
				nres    = ovf_q ? '0 : from_sm(neg_q, p_q);
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!ovld_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			op_q <= act_t'(req.action);
			a_q  <= req.operand_a[W-1:0];
			b_q  <= req.operand_b[W-1:0];
		end
		if (state_q == S_DEC) begin
			neg_q <= (op_q == ACT_POW) ? pneg : (a_q[W-1] ^ b_q[W-1]);
			p_q   <= ONE;
			ovf_q <= 1'b0;
			exp_q <= b_q[EB-1:0];
			rnd_q <= RW'(EB);
		end
		if ((state_q == S_PSQW || state_q == S_PMLW) && usts.done) begin
			p_q <= uacc[W-1:0];
			if (!step_ok) begin
				ovf_q <= 1'b1;
			end
			if (state_q == S_PMLW || !exp_q[EB-1]) begin
				exp_q <= {exp_q[EB-2:0], 1'b0};
				rnd_q <= rnd_q - 1'b1;
			end
		end
		if (set_res) begin
			res_q <= nres;
			st_q  <= nst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (state_q == S_FIN && (!ovld_q || rsp.ready)) begin
			ovld_q <= 1'b1;
		end else if (rsp.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!ovld_q || rsp.ready)) begin
			oval_q <= XW'(signed'(res_q));
			ost_q  <= st_q;
		end
	end

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = ovld_q;
	assign rsp.value  = oval_q;
	assign rsp.status = ost_q;

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.value == '0)
		else $error("nonzero value with error status");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("ready while request in flight");

	a_unit_done: assert property (@(posedge clk) disable iff (!arst_n)
		usts.done |-> state_q == S_MUL || state_q == S_DIV || state_q == S_PSQW
			|| state_q == S_PMLW)
		else $error("unit finished outside a wait state");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && state_d == S_IDLE |=> rsp.valid)
		else $error("finished result not presented");
`endif

endmodule

// File: dv/csa_checker.sv
module csa_checker import csa_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	csa_req_if.sink req_mon,
	csa_rsp_if.sink rsp_mon,
	output int      fail_count,
	output int      pending
);

	typedef struct {
		logic signed [XW-1:0] value;
		stat_t                status;
	} alu_result_t;

	alu_result_t expected_results[$];

	localparam logic [XW-1:0] MIN_NEG = {1'b1, {(XW-1){1'b0}}};

	function automatic logic [XW-1:0] mag_of(logic [XW-1:0] v);
		return v[XW-1] ? -v : v;
	endfunction

	function automatic alu_result_t signed_result(logic neg, logic [XW-1:0] m);
		alu_result_t r;
		r.value = '0;
		if (neg ? (m > MIN_NEG) : (m >= MIN_NEG)) begin
			r.status = ST_OVF;
		end else begin
			r.status = ST_OK;
			r.value = neg ? -m : m;
		end
		return r;
	endfunction

	function automatic alu_result_t compute_alu(logic [AW-1:0] act, logic [XW-1:0] a,
			logic [XW-1:0] b);
		alu_result_t r;
		logic [XW-1:0] s;
		logic [2*XW-1:0] prod;
		logic [XW-1:0] ma;
		logic [XW-1:0] p;
		logic neg;
		r.value = '0;
		r.status = ST_OK;
		case (act)
			ACT_ADD, ACT_SUB: begin
				s = (act == ACT_ADD) ? a + b : a - b;
				if ((act == ACT_ADD) ? (a[XW-1] == b[XW-1] && s[XW-1] != a[XW-1])
						: (a[XW-1] != b[XW-1] && s[XW-1] != a[XW-1]))
					r.status = ST_OVF;
				else
					r.value = s;
			end
			ACT_MUL: begin
				prod = {{XW{1'b0}}, mag_of(a)} * {{XW{1'b0}}, mag_of(b)};
				if (prod == 0)
					r.value = '0;
				else if (prod[2*XW-1:XW] != 0)
					r.status = ST_OVF;
				else
					r = signed_result(a[XW-1] != b[XW-1], prod[XW-1:0]);
			end
			ACT_POW: begin
				ma = mag_of(a);
				neg = a[XW-1] & b[0];
				if (b[XW-1]) begin
					r.status = ST_NEGEXP;
				end else if (b == 0) begin
					r.value = XW'(1);
				end else if (ma <= 1) begin
					r = signed_result(neg, ma);
				end else if (b >= XW) begin
					r.status = ST_OVF;
				end else begin
					p = ma;
					for (int i = 1; i < b; i++) begin
						prod = {{XW{1'b0}}, p} * {{XW{1'b0}}, ma};
						if (prod[2*XW-1:XW] != 0 || (neg ? prod > MIN_NEG : prod >= MIN_NEG)) begin
							r.status = ST_OVF;
							break;
						end
						p = prod[XW-1:0];
					end
					if (r.status == ST_OK)
						r = signed_result(neg, p);
				end
			end
			ACT_DIV: begin
				if (b == 0)
					r.status = ST_DIV0;
				else
					r = signed_result(a[XW-1] != b[XW-1], mag_of(a) / mag_of(b));
			end
			default: ;
		endcase
		if (r.status != ST_OK)
			r.value = '0;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	assign pending = expected_results.size();

	always @(posedge clk) begin
		alu_result_t e;
		if (!arst_n) begin
			fail_count = 0;
		end else begin
			if (req_mon.valid && req_mon.ready)
				expected_results.push_back(compute_alu(req_mon.action, req_mon.operand_a,
					req_mon.operand_b));
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request waiting");
				end else begin
					e = expected_results.pop_front();
					if (rsp_mon.value !== e.value)
						report_mismatch($sformatf("value %0d, want %0d", rsp_mon.value, e.value));
					if (rsp_mon.status !== e.status)
						report_mismatch($sformatf("status %0d, want %0d", rsp_mon.status,
							e.status));
				end
			end
		end
	end

endmodule

// File: dv/tb_checked_signed_alu.sv
module tb_checked_signed_alu;
	import csa_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam logic [XW-1:0] MIN_NEG = {1'b1, {(XW-1){1'b0}}};
	localparam logic [XW-1:0] MAX_POS = {1'b0, {(XW-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   idle_cycles = 0;

	csa_req_if req ();
	csa_rsp_if rsp ();

	checked_signed_alu #(.DATA_WIDTH(XW)) dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	csa_checker chk (.clk(clk), .arst_n(arst_n), .req_mon(req), .rsp_mon(rsp),
		.fail_count(fail_count), .pending(pending));

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 80);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [XW-1:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return MIN_NEG;
			1: return MAX_POS;
			2: return XW'($signed($urandom_range(0, 8)) - 4);
			3: return XW'($signed($urandom_range(0, 200)) - 100);
			4: return {$urandom, $urandom};
			5: return XW'($signed($urandom));
			6: return XW'(1) << $urandom_range(0, XW-1);
			default: return {{32{1'b0}}, $urandom} >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic send_request(logic [AW-1:0] act, logic [XW-1:0] a, logic [XW-1:0] b);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.operand_a <= a;
		req.operand_b <= b;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if ($urandom_range(0, 9) < 3)
			rsp.ready <= 1'b0;
		else if ($urandom_range(0, 30) == 0)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [XW-1:0] a;
		logic [XW-1:0] b;
		logic [AW-1:0] act;
		req.valid = 1'b0;
		req.action = '0;
		req.operand_a = '0;
		req.operand_b = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_request(ACT_ADD, MAX_POS, XW'(1));
		send_request(ACT_ADD, MIN_NEG, XW'(-1));
		send_request(ACT_ADD, MIN_NEG, MAX_POS);
		send_request(ACT_SUB, MIN_NEG, XW'(1));
		send_request(ACT_SUB, XW'(0), MIN_NEG);
		send_request(ACT_SUB, XW'(-1), MIN_NEG);
		send_request(ACT_MUL, MIN_NEG, XW'(-1));
		send_request(ACT_MUL, MIN_NEG, XW'(1));
		send_request(ACT_MUL, XW'(0), MIN_NEG);
		send_request(ACT_MUL, 64'h1_0000_0000, 64'h8000_0000);
		send_request(ACT_MUL, 64'h1_0000_0000, -64'sh8000_0000);
		send_request(ACT_POW, XW'(0), XW'(0));
		send_request(ACT_POW, XW'(0), XW'(-1));
		send_request(ACT_POW, XW'(5), MIN_NEG);
		send_request(ACT_POW, XW'(-2), XW'(63));
		send_request(ACT_POW, XW'(2), XW'(63));
		send_request(ACT_POW, XW'(-1), MAX_POS);
		send_request(ACT_POW, XW'(3), XW'(39));
		send_request(ACT_POW, XW'(3), XW'(40));
		send_request(ACT_DIV, MIN_NEG, XW'(-1));
		send_request(ACT_DIV, MAX_POS, XW'(0));
		send_request(ACT_DIV, XW'(-7), XW'(2));
		send_request(ACT_DIV, MIN_NEG, MAX_POS);
		send_request(3'd5, MIN_NEG, MAX_POS);
		send_request(3'd7, XW'(-1), XW'(-1));
		repeat (450) begin
			act = $urandom_range(0, 19) == 0 ? AW'($urandom_range(5, 7))
				: AW'($urandom_range(0, 4));
			a = pick_operand();
			b = pick_operand();
			if (act == ACT_POW && $urandom_range(0, 3) != 0)
				b = XW'($urandom_range(0, 70));
			if (act == ACT_DIV && $urandom_range(0, 15) == 0)
				b = '0;
			send_request(act, a, b);
		end
		req.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
